[sv/bnsi_pkg.sv]
// Shared types and constants of the base-N string to integer converter.
package bnsi_pkg;

   // Alphabet storage and field widths.
   localparam int SYM_SLOTS = 16;
   localparam int CHAR_W    = 8;
   localparam int VALUE_W   = 32;
   localparam int BASE_W    = 5;
   localparam int DIGIT_W   = 4;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 2;

   // Character codes used by the prefix and alphabet checks.
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   // Radix after reset.
   localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_NO_MATCH = 2'd2
   } status_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SYMBOLS_LOW  = 2'd0,
      REG_SYMBOLS_HIGH = 2'd1,
      REG_BASE_SIZE    = 2'd2
   } reg_index_type;

   // Configuration view handed from the register block to the datapath.
   typedef struct packed {
      logic [SYM_SLOTS-1:0][CHAR_W-1:0] symbols;
      logic [BASE_W-1:0]                base_size;
      logic                             alphabet_ok;
   } cfg_type;

endpackage

[sv/bnsi_if.sv]
// Valid/ready channel interfaces for characters in and converted results out.
interface bnsi_req_if;
   logic                         valid;
   logic                         ready;
   logic [bnsi_pkg::CHAR_W-1:0]  char_in;
   logic                         is_last;

   modport source (output valid, output char_in, output is_last, input ready);
   modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

interface bnsi_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [bnsi_pkg::VALUE_W-1:0] value;
   logic [1:0]                          status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

[sv/bnsi_cfg.sv]
// Configuration registers and the alphabet validity check.
module bnsi_cfg #(
   parameter int MAX_SYMBOLS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [bnsi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bnsi_pkg::CSR_W-1:0]           csr_wdata,
   output bnsi_pkg::cfg_type                    cfg
);
   import bnsi_pkg::*;

   logic [CSR_W-1:0]  symbols_low_ff,  symbols_low_in;
   logic [CSR_W-1:0]  symbols_high_ff, symbols_high_in;
   logic [BASE_W-1:0] base_size_ff,    base_size_in;
   logic [SYM_SLOTS-1:0][CHAR_W-1:0] symbols;
   logic              alphabet_ok;

   // Register writes; an index beyond the list is ignored.
   always_comb begin
      symbols_low_in  = symbols_low_ff;
      symbols_high_in = symbols_high_ff;
      base_size_in    = base_size_ff;
      if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_SYMBOLS_LOW:  symbols_low_in  = csr_wdata;
            REG_SYMBOLS_HIGH: symbols_high_in = csr_wdata;
            REG_BASE_SIZE:    base_size_in    = csr_wdata[BASE_W-1:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         symbols_low_ff  <= '0;
         symbols_high_ff <= '0;
         base_size_ff    <= BASE_RESET;
      end else begin
         symbols_low_ff  <= symbols_low_in;
         symbols_high_ff <= symbols_high_in;
         base_size_ff    <= base_size_in;
      end
   end

   assign symbols = {symbols_high_ff, symbols_low_ff};

   // The alphabet is valid when the radix is in range and every used symbol
   // is unique and none of the reserved characters.
   always_comb begin
      alphabet_ok = (base_size_ff >= BASE_W'(2)) && (base_size_ff <= BASE_W'(MAX_SYMBOLS));
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         if (BASE_W'(i) < base_size_ff) begin
            if (symbols[i] == CHAR_PLUS || symbols[i] == CHAR_MINUS ||
                symbols[i] == CHAR_SPACE || symbols[i] == CHAR_NUL) begin
               alphabet_ok = 1'b0;
            end
            for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
               if (BASE_W'(j) < base_size_ff && symbols[j] == symbols[i]) begin
                  alphabet_ok = 1'b0;
               end
            end
         end
      end
   end

   assign cfg.symbols     = symbols;
   assign cfg.base_size   = base_size_ff;
   assign cfg.alphabet_ok = alphabet_ok;

endmodule

[sv/bnsi_core.sv]
// Per-character conversion state and the result register.
module bnsi_core #(
   parameter int MAX_SYMBOLS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  bnsi_pkg::cfg_type cfg,
   bnsi_req_if.sink          req_chan,
   bnsi_rsp_if.source        rsp_chan
);
   import bnsi_pkg::*;

   logic [VALUE_W-1:0]  acc_ff, acc_in;
   logic                negative_ff, negative_in;
   logic                in_digits_ff, in_digits_in;
   logic                mismatch_ff, mismatch_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   status_type          status_ff, status_in;

   logic                req_fire;
   logic [CHAR_W-1:0]   chr;
   logic                is_prefix;
   logic [BASE_W-1:0]   used_count;
   logic                found;
   logic [DIGIT_W-1:0]  digit;
   logic [VALUE_W-1:0]  product;

   // A new transaction enters whenever the result register is free or drains.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign chr            = req_chan.char_in;

   // Whitespace and sign characters that the prefix skips.
   assign is_prefix = (chr == CHAR_PLUS) || (chr == CHAR_MINUS) || (chr == CHAR_SPACE) ||
                      ((chr >= CHAR_TAB) && (chr <= CHAR_CR));

   assign used_count = (cfg.base_size > BASE_W'(MAX_SYMBOLS)) ? BASE_W'(MAX_SYMBOLS)
                                                              : cfg.base_size;

   // Parallel alphabet match; the lowest matching slot gives the digit.
   always_comb begin
      found = 1'b0;
      digit = '0;
      for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
         if (BASE_W'(i) < used_count && cfg.symbols[i] == chr) begin
            found = 1'b1;
            digit = DIGIT_W'(i);
         end
      end
   end

   // One multiply-add per digit, wrapping at the accumulator width.
   assign product = acc_ff * {{(VALUE_W-BASE_W){1'b0}}, cfg.base_size};

   // State update and result formation for an accepted character.
   always_comb begin
      acc_in       = acc_ff;
      negative_in  = negative_ff;
      in_digits_in = in_digits_ff;
      mismatch_in  = mismatch_ff;
      rsp_valid_in = rsp_valid_ff;
      value_in     = value_ff;
      status_in    = status_ff;

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_fire) begin
         if (!mismatch_ff) begin
            if (!in_digits_ff && is_prefix) begin
               if (chr == CHAR_MINUS) begin
                  negative_in = !negative_ff;
               end
            end else begin
               in_digits_in = 1'b1;
               if (!found) begin
                  mismatch_in = 1'b1;
               end else begin
                  acc_in = product + {{(VALUE_W-DIGIT_W){1'b0}}, digit};
               end
            end
         end

         // The marked character closes the string and loads the result.
         if (req_chan.is_last) begin
            rsp_valid_in = 1'b1;
            priority if (!cfg.alphabet_ok) begin
               status_in = STATUS_INVALID;
               value_in  = '0;
            end else if (mismatch_in || !in_digits_in) begin
               status_in = STATUS_NO_MATCH;
               value_in  = '0;
            end else begin
               status_in = STATUS_OK;
               value_in  = negative_in ? (VALUE_W'(0) - acc_in) : acc_in;
            end
            acc_in       = '0;
            negative_in  = 1'b0;
            in_digits_in = 1'b0;
            mismatch_in  = 1'b0;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         negative_ff  <= 1'b0;
         in_digits_ff <= 1'b0;
         mismatch_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         negative_ff  <= negative_in;
         in_digits_ff <= in_digits_in;
         mismatch_ff  <= mismatch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.value  = value_ff;
   assign rsp_chan.status = status_ff;

endmodule

[sv/base_n_string_to_integer_top.sv]
// Top level of the base-N string to integer converter.
//
// Characters arrive one per transaction on req_chan (char_in, is_last), with
// the final character of a string marked by is_last. Leading whitespace and
// signs are skipped, each '-' flips the sign, and the remaining characters
// are digits of the alphabet held in the csr_ registers (two 64-bit words of
// symbols and a 5-bit radix, written by index with csr_wr_en).
// One result transaction (value, status) leaves on rsp_chan per string, in the
// cycle after its marked character is accepted. A character is taken every
// clock while req_chan.ready is high: the alphabet compare and the accumulator
// multiply-add complete combinationally between acceptance and the state and
// result registers. Reset clears the string state and the result valid flag,
// sets the radix to 10, the symbols to zero. While a result waits unaccepted,
// req_chan still takes a character in the cycle that rsp_chan.ready drains
// it; otherwise req_chan.ready stays low until the result is taken.
module base_n_string_to_integer_top #(
   parameter int MAX_SYMBOLS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [bnsi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bnsi_pkg::CSR_W-1:0]       csr_wdata,
   bnsi_req_if.sink                         req_chan,
   bnsi_rsp_if.source                       rsp_chan
);
   import bnsi_pkg::*;

   cfg_type cfg;

   // Configuration registers and alphabet check.
   bnsi_cfg #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Conversion datapath and result register.
   bnsi_core #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

[tb/tb_top.sv]
// Self-checking testbench of the base-N string to integer converter.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bnsi_pkg::*;

   localparam int MAX_SYM = SYM_SLOTS;
   // The index after the last register; writes to it must be ignored.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASES = 18;
   localparam int CHARS_PER_PHASE = 100;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } char_item_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      status_type                status;
   } conv_result_type;

   typedef enum int {FLAW_RADIX, FLAW_RESERVED, FLAW_REPEAT} flaw_kind_type;
   typedef enum int {STR_NUMBER, STR_BROKEN, STR_NOISE, STR_PREFIX_ONLY} string_kind_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   bnsi_req_if req_chan ();
   bnsi_rsp_if rsp_chan ();

   base_n_string_to_integer_top #(.MAX_SYMBOLS(MAX_SYM)) DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   // Shadow of the alphabet registers, kept in step with every write.
   logic [CSR_W-1:0]  alpha_lo    = '0;
   logic [CSR_W-1:0]  alpha_hi    = '0;
   logic [BASE_W-1:0] alpha_radix = BASE_RESET;

   // Per-string conversion state of the predictor.
   logic [VALUE_W-1:0] acc;
   logic               neg;
   logic               digits_seen;
   logic               bad_char;

   char_item_type   pending_chars[$];
   conv_result_type expected_results[$];

   int send_gap_max = 5;
   int rcv_gap_max  = 5;
   int send_wait;
   int rsp_wait;
   logic hold_trigger = 1'b0;
   logic rsp_hold_on  = 1'b0;

   int mismatch_count  = 0;
   int chars_queued    = 0;
   int strings_queued  = 0;
   int chars_accepted  = 0;
   int results_seen    = 0;
   int settings_loaded = 0;

   // Free-running clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic int draw_gap(int max_gap);
      return (max_gap == 0) ? 0 : int'($urandom_range(0, max_gap));
   endfunction

   function automatic logic [CHAR_W-1:0] sym(int idx);
      logic [CSR_W-1:0] w;
      w = (idx < 8) ? alpha_lo : alpha_hi;
      return w[(idx % 8) * 8 +: 8];
   endfunction

   function automatic bit is_blank(logic [CHAR_W-1:0] c);
      return (c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE;
   endfunction

   // The alphabet needs 2..16 symbols, none reserved and none repeated.
   function automatic bit alphabet_ok();
      int n;
      logic [CHAR_W-1:0] s;
      n = int'(alpha_radix);
      if (n < 2 || n > MAX_SYM) return 1'b0;
      for (int i = 0; i < n; i++) begin
         s = sym(i);
         if (s == CHAR_PLUS || s == CHAR_MINUS || s == CHAR_SPACE || s == CHAR_NUL)
            return 1'b0;
         for (int j = i + 1; j < n; j++)
            if (sym(j) == s) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Lowest matching symbol index, or -1 when the character is no digit.
   function automatic int digit_of(logic [CHAR_W-1:0] c);
      int n;
      n = (int'(alpha_radix) > MAX_SYM) ? MAX_SYM : int'(alpha_radix);
      for (int i = 0; i < n; i++)
         if (sym(i) == c) return i;
      return -1;
   endfunction

   task automatic clear_string();
      acc = '0;
      neg = 1'b0;
      digits_seen = 1'b0;
      bad_char = 1'b0;
   endtask

   // Advance the predicted conversion by one accepted character.
   task automatic apply_char(logic [CHAR_W-1:0] c, logic last);
      int d;
      conv_result_type r;
      if (!bad_char) begin
         if (!digits_seen && (c == CHAR_PLUS || c == CHAR_MINUS || is_blank(c))) begin
            if (c == CHAR_MINUS) neg = !neg;
         end else begin
            d = digit_of(c);
            digits_seen = 1'b1;
            if (d < 0) bad_char = 1'b1;
            else acc = acc * VALUE_W'(alpha_radix) + VALUE_W'(d);
         end
      end
      if (last) begin
         if (!alphabet_ok()) begin
            r = '{value: '0, status: STATUS_INVALID};
         end else if (bad_char || !digits_seen) begin
            r = '{value: '0, status: STATUS_NO_MATCH};
         end else begin
            r = '{value: neg ? -acc : acc, status: STATUS_OK};
         end
         expected_results.push_back(r);
         clear_string();
      end
   endtask

   // Driver: offers queued characters with a random gap before each.
   always @(posedge clock) begin : driver
      char_item_type item;
      if (reset) begin
         req_chan.valid   <= 1'b0;
         req_chan.char_in <= '0;
         req_chan.is_last <= 1'b0;
         send_wait <= 0;
         clear_string();
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            apply_char(req_chan.char_in, req_chan.is_last);
            chars_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_wait > 0) begin
               send_wait <= send_wait - 1;
               req_chan.valid <= 1'b0;
            end else if (pending_chars.size() != 0) begin
               item = pending_chars.pop_front();
               req_chan.valid   <= 1'b1;
               req_chan.char_in <= item.ch;
               req_chan.is_last <= item.last;
               send_wait <= draw_gap(send_gap_max);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transaction and throttles ready.
   always @(posedge clock) begin : monitor
      conv_result_type want;
      int nxt;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_wait <= 0;
      end else begin
         nxt = (rsp_wait > 0) ? rsp_wait - 1 : 0;
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result value=%0d status=%0d",
                                         rsp_chan.value, rsp_chan.status));
            end else begin
               want = expected_results.pop_front();
               if (rsp_chan.value !== want.value)
                  report_mismatch($sformatf("value %0d, expected %0d",
                                            rsp_chan.value, want.value));
               if (rsp_chan.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_chan.status, want.status));
            end
            nxt = draw_gap(rcv_gap_max);
         end
         rsp_wait <= nxt;
         rsp_chan.ready <= (nxt == 0) && !rsp_hold_on;
      end
   end

   // Long receiver stall, so the block fills up and backs up its input.
   initial begin : rsp_hold
      wait (hold_trigger);
      @(posedge clock);
      rsp_hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold_on <= 1'b0;
   end

   // Watchdog.
   initial begin : watchdog
      #2_000_000;
      $display("timeout with %0d results still expected", expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic push_char(logic [CHAR_W-1:0] c, bit last);
      pending_chars.push_back('{ch: c, last: last});
      chars_queued++;
      if (last) strings_queued++;
   endtask

   task automatic push_string(string s, bit ends);
      for (int i = 0; i < s.len(); i++)
         push_char(s[i], ends && (i == s.len() - 1));
   endtask

   // Register write; the shadow follows once the write edge has passed.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_SYMBOLS_LOW:  alpha_lo = data;
         REG_SYMBOLS_HIGH: alpha_hi = data;
         REG_BASE_SIZE:    alpha_radix = data[BASE_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [CSR_W-1:0] radix_word(logic [BASE_W-1:0] radix);
      logic [CSR_W-1:0] w;
      w = {$urandom, $urandom};
      w[BASE_W-1:0] = radix;
      return w;
   endfunction

   // Builds a random alphabet of n symbols (random n when 0), valid or with one flaw.
   task automatic load_random_alphabet(bit make_valid, int n_pick);
      logic [CHAR_W-1:0] syms [SYM_SLOTS];
      logic [CHAR_W-1:0] reserved [4];
      logic [CSR_W-1:0] lo, hi;
      logic [CHAR_W-1:0] c;
      logic [BASE_W-1:0] radix;
      string digit_text;
      flaw_kind_type flaw;
      bit clash;
      int n, a, b;
      reserved = '{CHAR_NUL, CHAR_PLUS, CHAR_MINUS, CHAR_SPACE};
      digit_text = "0123456789ABCDEF";
      n = (n_pick != 0) ? n_pick : int'($urandom_range(2, MAX_SYM));
      // Slots beyond the radix keep arbitrary bytes, NUL included.
      for (int i = 0; i < SYM_SLOTS; i++) syms[i] = CHAR_W'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) begin
         for (int i = 0; i < n; i++) syms[i] = digit_text[i];
      end else begin
         for (int i = 0; i < n; i++) begin
            do begin
               c = ($urandom_range(0, 7) == 0) ? CHAR_W'($urandom_range(9, 13))
                                               : CHAR_W'($urandom_range(1, 255));
               clash = (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_SPACE);
               for (int j = 0; j < i; j++)
                  if (syms[j] == c) clash = 1'b1;
            end while (clash);
            syms[i] = c;
         end
      end
      radix = BASE_W'(n);
      if (!make_valid) begin
         flaw = flaw_kind_type'($urandom_range(0, 2));
         case (flaw)
            FLAW_RADIX:
               radix = $urandom_range(0, 1) ? BASE_W'($urandom_range(0, 1))
                                            : BASE_W'($urandom_range(17, 31));
            FLAW_RESERVED:
               syms[$urandom_range(0, n - 1)] = reserved[$urandom_range(0, 3)];
            FLAW_REPEAT: begin
               a = int'($urandom_range(0, n - 2));
               b = int'($urandom_range(a + 1, n - 1));
               syms[b] = syms[a];
            end
            default: ;
         endcase
      end
      for (int i = 0; i < 8; i++) begin
         lo[i * 8 +: 8] = syms[i];
         hi[i * 8 +: 8] = syms[8 + i];
      end
      write_csr(REG_SYMBOLS_LOW, lo);
      write_csr(REG_SYMBOLS_HIGH, hi);
      write_csr(REG_BASE_SIZE, radix_word(radix));
   endtask

   // Mostly well-formed numbers; the rest broken, noise or prefix only.
   task automatic push_random_string();
      logic [CHAR_W-1:0] text[$];
      logic [CHAR_W-1:0] prefix_set [8];
      string_kind_type kind;
      int used, np, nd, len;
      prefix_set = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, CHAR_SPACE, CHAR_PLUS, CHAR_MINUS};
      used = (int'(alpha_radix) > MAX_SYM) ? MAX_SYM : int'(alpha_radix);
      case ($urandom_range(0, 9))
         7: kind = STR_BROKEN;
         8: kind = STR_NOISE;
         9: kind = STR_PREFIX_ONLY;
         default: kind = STR_NUMBER;
      endcase
      np = (kind == STR_PREFIX_ONLY) ? int'($urandom_range(1, 4)) : int'($urandom_range(0, 3));
      nd = ($urandom_range(0, 7) == 0) ? int'($urandom_range(9, 14)) : int'($urandom_range(1, 8));
      if (kind == STR_NOISE) begin
         len = int'($urandom_range(1, 6));
         for (int i = 0; i < len; i++) text.push_back(CHAR_W'($urandom_range(0, 255)));
      end else begin
         for (int i = 0; i < np; i++) text.push_back(prefix_set[$urandom_range(0, 7)]);
         if (kind != STR_PREFIX_ONLY) begin
            for (int i = 0; i < nd; i++)
               text.push_back((used == 0) ? CHAR_W'($urandom_range(0, 255))
                                          : sym(int'($urandom_range(0, used - 1))));
         end
         if (kind == STR_BROKEN)
            text[$urandom_range(0, text.size() - 1)] = CHAR_W'($urandom_range(0, 255));
      end
      for (int i = 0; i < text.size(); i++)
         push_char(text[i], i == text.size() - 1);
   endtask

   // Waits until every character is taken and every result checked, plus a short pause.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_chars.size() != 0 || req_chan.valid || expected_results.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   // Stimulus sequence.
   initial begin : stimulus
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // The alphabet after reset is all NUL, so any string is rejected.
      @(negedge clock);
      push_string("5", 1'b1);
      wait_idle();

      // A write past the register list changes nothing.
      write_csr(REG_UNUSED, {$urandom, $urandom});
      write_csr(REG_SYMBOLS_LOW, 64'h3736353433323130);
      write_csr(REG_SYMBOLS_HIGH, 64'h0000000000003938);
      write_csr(REG_BASE_SIZE, radix_word(5'd10));
      settings_loaded++;

      // Signs, a bad digit, no digits, NUL and the top byte code.
      @(negedge clock);
      push_string(" +-7", 1'b1);
      push_string("--5", 1'b1);
      push_string("12a", 1'b1);
      push_string(" -", 1'b1);
      push_char(CHAR_NUL, 1'b1);
      push_char(8'hFF, 1'b1);
      // The first digit of a string whose alphabet changes before its end.
      push_string("9", 1'b0);
      wait_idle();

      write_csr(REG_SYMBOLS_HIGH, 64'h4645444342413938);
      write_csr(REG_BASE_SIZE, radix_word(5'd16));
      settings_loaded++;
      @(negedge clock);
      push_string("F", 1'b1);
      // Most negative value.
      push_string("80000000", 1'b1);
      wait_idle();

      // Random phases, each with a new alphabet.
      for (int p = 0; p < PHASES; p++) begin
         send_gap_max = (p % 4 == 3) ? 0 : 5;
         rcv_gap_max  = (p % 4 == 3) ? 0 : 5;
         case (p)
            0: load_random_alphabet(1'b1, 2);
            1: load_random_alphabet(1'b1, MAX_SYM);
            2: begin
               load_random_alphabet(1'b1, 0);
               write_csr(REG_BASE_SIZE, radix_word(5'd0));
            end
            3: begin
               load_random_alphabet(1'b1, 0);
               write_csr(REG_BASE_SIZE, radix_word(5'h1F));
            end
            default: load_random_alphabet($urandom_range(0, 3) != 0, 0);
         endcase
         if ($urandom_range(0, 1) == 1) write_csr(REG_UNUSED, {$urandom, $urandom});
         settings_loaded++;
         @(negedge clock);
         begin : fill
            int target;
            target = chars_queued + CHARS_PER_PHASE;
            while (chars_queued < target) push_random_string();
         end
         if (p == 6) hold_trigger = 1'b1;
         wait_idle();
      end

      repeat (4) @(posedge clock);
      $display("Converted %0d characters in %0d strings across %0d alphabet settings.",
               chars_accepted, strings_queued, settings_loaded);
      $display("Checked %0d results, %0d mismatches.", results_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
